/* src/crs_pkg.sv */
// ----------------------------------------------------------------------------
// Catmull-Rom sampler package
// Shared payload types, arithmetic widths and register map of the uniform
// Catmull-Rom segment sampler.
// ----------------------------------------------------------------------------
package crs_pkg;

   // Coordinate format: signed Q16.16.
   localparam int CRD_W = 32;
   localparam int FRAC  = 16;

   // Segment parameter u in unsigned Q1.16, 0 to 1.0 inclusive.
   localparam int U_W      = 17;
   localparam int ONE_Q16  = 65536;

   // Datapath widths: first and second lerp levels, differences, weights and
   // products. The weight 1+u reaches 2.0, which needs 19 signed bits.
   localparam int A_W = 36;
   localparam int D_W = 37;
   localparam int W_W = 19;
   localparam int P_W = D_W + W_W;

   // Register stages from sample issue to the output register.
   localparam int PIPE_LAT = 7;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int SPS_W      = 7;
   localparam logic [SPS_W-1:0] SPS_RESET = 7'd16;

   // Register indexes (word address).
   localparam logic REG_SPS = 1'b0;

   // Four control points of one segment.
   typedef struct packed {
      logic signed [CRD_W-1:0] ctrl0_x;
      logic signed [CRD_W-1:0] ctrl0_y;
      logic signed [CRD_W-1:0] ctrl0_z;
      logic signed [CRD_W-1:0] ctrl1_x;
      logic signed [CRD_W-1:0] ctrl1_y;
      logic signed [CRD_W-1:0] ctrl1_z;
      logic signed [CRD_W-1:0] ctrl2_x;
      logic signed [CRD_W-1:0] ctrl2_y;
      logic signed [CRD_W-1:0] ctrl2_z;
      logic signed [CRD_W-1:0] ctrl3_x;
      logic signed [CRD_W-1:0] ctrl3_y;
      logic signed [CRD_W-1:0] ctrl3_z;
   } req_data_type;

   // One sample on the curve.
   typedef struct packed {
      logic signed [CRD_W-1:0] sample_x;
      logic signed [CRD_W-1:0] sample_y;
      logic signed [CRD_W-1:0] sample_z;
      logic                    last_sample;
   } rsp_data_type;

   // Sample issued by the sequencer into the lerp pipeline.
   typedef struct packed {
      logic           valid;
      logic           last;
      logic [U_W-1:0] u;
   } smp_type;

endpackage

/* src/crs_sequencer.sv */
// ----------------------------------------------------------------------------
// Catmull-Rom sampler sequencer
// Holds one request and issues its samples, one parameter value u per enabled
// cycle, stepping u by a table-driven quotient and remainder instead of dividing.
// ----------------------------------------------------------------------------
module crs_sequencer #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  crs_pkg::req_data_type req_data,
   input  logic [crs_pkg::SPS_W-1:0] sps,
   output crs_pkg::smp_type      smp,
   output crs_pkg::req_data_type pts
);
   import crs_pkg::*;

   localparam int IW     = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
   localparam int TAB_N  = 1 << IW;

   // Step table: 65536 = q*d + r for every divisor d = n-1.
   logic [U_W-1:0] q_tab [TAB_N];
   logic [IW-1:0]  r_tab [TAB_N];

   for (genvar g = 0; g < TAB_N; g++) begin : g_step
      localparam int DIV    = (g == 0) ? 1 : g;
      localparam int STEP_Q = ONE_Q16 / DIV;
      localparam int STEP_R = ONE_Q16 % DIV;
      assign q_tab[g] = U_W'(STEP_Q);
      assign r_tab[g] = IW'(STEP_R);
   end

   logic               busy_ff, busy_in;
   logic [IW-1:0]      i_ff, i_in;
   logic [IW-1:0]      d_ff, d_in;
   logic [U_W-1:0]     q_ff, q_in;
   logic [IW-1:0]      rs_ff, rs_in;
   logic [U_W-1:0]     u_ff, u_in;
   logic [IW-1:0]      r_ff, r_in;
   req_data_type       pts_ff, pts_in;

   logic [SPS_W-1:0]   n_c;
   logic [IW-1:0]      d_c;
   logic [IW:0]        r_sum;
   logic               wrap;
   logic               last_c;
   logic               take;
   logic               accept;

   // Clamp the sample count to the supported range.
   always_comb begin
      if (sps < SPS_W'(2)) begin
         n_c = SPS_W'(2);
      end else if (sps > SPS_W'(MAX_SAMPLES)) begin
         n_c = SPS_W'(MAX_SAMPLES);
      end else begin
         n_c = sps;
      end
      d_c = IW'(n_c - SPS_W'(1));
   end

   // Handshake: a new request enters as the last sample of the current one leaves.
   assign last_c    = (i_ff == d_ff);
   assign take      = busy_ff && en;
   assign req_stall = busy_ff && !(en && last_c);
   assign accept    = req_valid && !req_stall;

   // Remainder accumulation: carry one extra unit into u when it wraps.
   assign r_sum = {1'b0, r_ff} + {1'b0, rs_ff};
   assign wrap  = (r_sum >= {1'b0, d_ff});

   always_comb begin
      busy_in = busy_ff;
      i_in    = i_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      rs_in   = rs_ff;
      u_in    = u_ff;
      r_in    = r_ff;
      pts_in  = pts_ff;
      if (accept) begin
         busy_in = 1'b1;
         i_in    = '0;
         d_in    = d_c;
         q_in    = q_tab[d_c];
         rs_in   = r_tab[d_c];
         u_in    = '0;
         r_in    = '0;
         pts_in  = req_data;
      end else if (take && last_c) begin
         busy_in = 1'b0;
      end else if (take) begin
         i_in = i_ff + IW'(1);
         u_in = u_ff + q_ff + U_W'(wrap);
         r_in = wrap ? IW'(r_sum - {1'b0, d_ff}) : IW'(r_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      rs_ff  <= rs_in;
      u_ff   <= u_in;
      r_ff   <= r_in;
      pts_ff <= pts_in;
   end

   assign smp.valid = busy_ff;
   assign smp.last  = last_c;
   assign smp.u     = u_ff;
   assign pts       = pts_ff;

endmodule

/* src/crs_lane.sv */
// ----------------------------------------------------------------------------
// Catmull-Rom sampler coordinate lane
// Seven-stage pipeline of the Barry-Goldman lerp pyramid for one coordinate,
// with a multiply stage between every two add stages and a saturating output.
// ----------------------------------------------------------------------------
module crs_lane (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [crs_pkg::CRD_W-1:0] p0,
   input  logic signed [crs_pkg::CRD_W-1:0] p1,
   input  logic signed [crs_pkg::CRD_W-1:0] p2,
   input  logic signed [crs_pkg::CRD_W-1:0] p3,
   input  logic [crs_pkg::U_W-1:0]        u,
   output logic signed [crs_pkg::CRD_W-1:0] c
);
   import crs_pkg::*;

   // Stage 1: point differences and first-level weights.
   logic signed [D_W-1:0]   d01_s1_ff, d12_s1_ff, d23_s1_ff;
   logic signed [CRD_W-1:0] p0_s1_ff, p1_s1_ff, p2_s1_ff;
   logic signed [W_W-1:0]   w1_s1_ff, w2_s1_ff, w3_s1_ff;
   logic [U_W-1:0]          u_s1_ff;
   logic signed [W_W-1:0]   u_w;

   assign u_w = $signed(W_W'(u));

   always_ff @(posedge clock) begin
      if (en) begin
         d01_s1_ff <= D_W'(p1) - D_W'(p0);
         d12_s1_ff <= D_W'(p2) - D_W'(p1);
         d23_s1_ff <= D_W'(p3) - D_W'(p2);
         p0_s1_ff  <= p0;
         p1_s1_ff  <= p1;
         p2_s1_ff  <= p2;
         w1_s1_ff  <= u_w + W_W'(ONE_Q16);
         w2_s1_ff  <= u_w;
         w3_s1_ff  <= u_w - W_W'(ONE_Q16);
         u_s1_ff   <= u;
      end
   end

   // Stage 2: first-level products.
   logic signed [P_W-1:0]   m1_s2_ff, m2_s2_ff, m3_s2_ff;
   logic signed [CRD_W-1:0] p0_s2_ff, p1_s2_ff, p2_s2_ff;
   logic [U_W-1:0]          u_s2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m1_s2_ff <= d01_s1_ff * w1_s1_ff;
         m2_s2_ff <= d12_s1_ff * w2_s1_ff;
         m3_s2_ff <= d23_s1_ff * w3_s1_ff;
         p0_s2_ff <= p0_s1_ff;
         p1_s2_ff <= p1_s1_ff;
         p2_s2_ff <= p2_s1_ff;
         u_s2_ff  <= u_s1_ff;
      end
   end

   // Stage 3: points A1..A3 (floored lerps) and their differences.
   logic signed [A_W-1:0]   a1_c, a2_c, a3_c;
   logic signed [A_W-1:0]   a1_s3_ff, a2_s3_ff;
   logic signed [D_W-1:0]   e12_s3_ff, e23_s3_ff;
   logic [U_W-1:0]          u_s3_ff;

   assign a1_c = A_W'(p0_s2_ff) + A_W'(m1_s2_ff >>> FRAC);
   assign a2_c = A_W'(p1_s2_ff) + A_W'(m2_s2_ff >>> FRAC);
   assign a3_c = A_W'(p2_s2_ff) + A_W'(m3_s2_ff >>> FRAC);

   always_ff @(posedge clock) begin
      if (en) begin
         a1_s3_ff  <= a1_c;
         a2_s3_ff  <= a2_c;
         e12_s3_ff <= D_W'(a2_c) - D_W'(a1_c);
         e23_s3_ff <= D_W'(a3_c) - D_W'(a2_c);
         u_s3_ff   <= u_s2_ff;
      end
   end

   // Stage 4: second-level products with the halved weights.
   logic [U_W:0]            wsum;
   logic signed [W_W-1:0]   wb1, wb2;
   logic signed [P_W-1:0]   n1_s4_ff, n2_s4_ff;
   logic signed [A_W-1:0]   a1_s4_ff, a2_s4_ff;
   logic [U_W-1:0]          u_s4_ff;

   assign wsum = {1'b0, u_s3_ff} + (U_W+1)'(ONE_Q16);
   assign wb1  = $signed(W_W'(wsum[U_W:1]));
   assign wb2  = $signed(W_W'(u_s3_ff[U_W-1:1]));

   always_ff @(posedge clock) begin
      if (en) begin
         n1_s4_ff <= e12_s3_ff * wb1;
         n2_s4_ff <= e23_s3_ff * wb2;
         a1_s4_ff <= a1_s3_ff;
         a2_s4_ff <= a2_s3_ff;
         u_s4_ff  <= u_s3_ff;
      end
   end

   // Stage 5: points B1, B2 and their difference.
   logic signed [A_W-1:0]   b1_c, b2_c;
   logic signed [A_W-1:0]   b1_s5_ff;
   logic signed [D_W-1:0]   f_s5_ff;
   logic [U_W-1:0]          u_s5_ff;

   assign b1_c = a1_s4_ff + A_W'(n1_s4_ff >>> FRAC);
   assign b2_c = a2_s4_ff + A_W'(n2_s4_ff >>> FRAC);

   always_ff @(posedge clock) begin
      if (en) begin
         b1_s5_ff <= b1_c;
         f_s5_ff  <= D_W'(b2_c) - D_W'(b1_c);
         u_s5_ff  <= u_s4_ff;
      end
   end

   // Stage 6: final product.
   logic signed [P_W-1:0]   k_s6_ff;
   logic signed [A_W-1:0]   b1_s6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         k_s6_ff  <= f_s5_ff * $signed(W_W'(u_s5_ff));
         b1_s6_ff <= b1_s5_ff;
      end
   end

   // Stage 7: point C, saturated to the 32-bit coordinate range.
   logic signed [A_W-1:0]   c_c;
   logic                    ovf;
   logic signed [CRD_W-1:0] c_ff, c_in;

   assign c_c = b1_s6_ff + A_W'(k_s6_ff >>> FRAC);
   assign ovf = !((&c_c[A_W-1:CRD_W-1]) || !(|c_c[A_W-1:CRD_W-1]));

   always_comb begin
      if (!ovf) begin
         c_in = c_c[CRD_W-1:0];
      end else if (c_c[A_W-1]) begin
         c_in = {1'b1, {(CRD_W-1){1'b0}}};
      end else begin
         c_in = {1'b0, {(CRD_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff <= c_in;
      end
   end

   assign c = c_ff;

endmodule

/* src/catmull_rom_spline_sampler.sv */
// ----------------------------------------------------------------------------
// Catmull-Rom spline sampler
// Samples the uniform Catmull-Rom segment between the middle two of four
// control points, evenly in u, through a pipelined Barry-Goldman pyramid.
// ----------------------------------------------------------------------------
// One request yields samples_per_segment samples (clamped to 2..MAX_SAMPLES,
// 16 after reset), and the block issues one sample per cycle while the result
// side does not stall, so a request occupies the input until its last sample
// is issued. The next request is accepted in the cycle the last sample of the
// current one is issued, so requests follow without gaps. A sample passes
// through the lerp pyramid stages to the output register. A stall on the
// result side holds the whole pipeline and, through it, the request side.
module catmull_rom_spline_sampler #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  crs_pkg::req_data_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output crs_pkg::rsp_data_type               rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [crs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [crs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [crs_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import crs_pkg::*;

   // Configuration register.
   logic [SPS_W-1:0] sps_ff, sps_in;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[CSR_ADDR_W-1:2] == REG_SPS);
   assign sps_in     = csr_wr ? csr_pwdata[SPS_W-1:0] : sps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sps_ff <= SPS_RESET;
      end else begin
         sps_ff <= sps_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[CSR_ADDR_W-1:2])
         REG_SPS: csr_prdata = CSR_DATA_W'(sps_ff);
         default: csr_prdata = '0;
      endcase
   end

   // The pipeline advances whenever the output register is free or taken.
   logic en;
   assign en = !(rsp_valid && rsp_stall);

   // Sample sequencer.
   smp_type      smp;
   req_data_type pts;

   crs_sequencer #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .sps       (sps_ff),
      .smp       (smp),
      .pts       (pts)
   );

   // One lerp pyramid per coordinate.
   logic signed [CRD_W-1:0] cx, cy, cz;

   crs_lane u_lane_x (
      .clock (clock),
      .en    (en),
      .p0    (pts.ctrl0_x),
      .p1    (pts.ctrl1_x),
      .p2    (pts.ctrl2_x),
      .p3    (pts.ctrl3_x),
      .u     (smp.u),
      .c     (cx)
   );

   crs_lane u_lane_y (
      .clock (clock),
      .en    (en),
      .p0    (pts.ctrl0_y),
      .p1    (pts.ctrl1_y),
      .p2    (pts.ctrl2_y),
      .p3    (pts.ctrl3_y),
      .u     (smp.u),
      .c     (cy)
   );

   crs_lane u_lane_z (
      .clock (clock),
      .en    (en),
      .p0    (pts.ctrl0_z),
      .p1    (pts.ctrl1_z),
      .p2    (pts.ctrl2_z),
      .p3    (pts.ctrl3_z),
      .u     (smp.u),
      .c     (cz)
   );

   // Valid and last flags travel alongside the lane stages.
   logic vld_ff  [PIPE_LAT];
   logic last_ff [PIPE_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PIPE_LAT; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= smp.valid;
         for (int s = 1; s < PIPE_LAT; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_ff[0] <= smp.last;
         for (int s = 1; s < PIPE_LAT; s++) begin
            last_ff[s] <= last_ff[s-1];
         end
      end
   end

   // Result channel.
   assign rsp_valid            = vld_ff[PIPE_LAT-1];
   assign rsp_data.sample_x    = cx;
   assign rsp_data.sample_y    = cy;
   assign rsp_data.sample_z    = cz;
   assign rsp_data.last_sample = last_ff[PIPE_LAT-1];

endmodule

/* bench/catmull_rom_spline_sampler_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Catmull-Rom spline sampler checker
// Watches the request, sample and register channels of the sampler, computes
// every curve sample that an accepted request must produce, and compares the
// samples that leave the block against them in order.
// ----------------------------------------------------------------------------
module catmull_rom_spline_sampler_checker #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  crs_pkg::req_data_type               req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  crs_pkg::rsp_data_type               rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [crs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [crs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input  logic [crs_pkg::CSR_DATA_W-1:0]      csr_prdata,
   input  logic                                csr_pready,
   output int                                  mismatch_count,
   output int                                  samples_pending,
   output int                                  segments_seen,
   output int                                  samples_checked
);
   import crs_pkg::*;

   localparam int REQ_W      = $bits(req_data_type);
   localparam int NUM_FIELDS = 12;
   localparam int MAX_SHOWN  = 10;
   localparam logic [CSR_ADDR_W-1:0] SPS_ADDR = {REG_SPS, 2'b00};
   localparam longint COORD_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint COORD_MIN = 64'shFFFF_FFFF_8000_0000;

   logic [SPS_W-1:0] sps_cfg;
   rsp_data_type     expected_samples[$];

   // Weighted blend of two wide coordinates; the weight is signed Q.16 and the
   // product is floored by the arithmetic shift.
   function automatic longint blend(input longint a, input longint b, input longint w);
      return a + (((b - a) * w) >>> FRAC);
   endfunction

   // One coordinate of the curve at parameter u, through the three levels of
   // the pyramid, saturated to the signed 32-bit range only at the end.
   function automatic logic [CRD_W-1:0] curve_coord(input logic [REQ_W-1:0] flat,
                                                    input int axis, input longint u);
      longint q[4];
      longint a1, a2, a3, b1, b2, c;
      for (int k = 0; k < 4; k++) begin
         q[k] = $signed(flat[CRD_W*(NUM_FIELDS-1-(3*k+axis)) +: CRD_W]);
      end
      a1 = blend(q[0], q[1], ONE_Q16 + u);
      a2 = blend(q[1], q[2], u);
      a3 = blend(q[2], q[3], u - ONE_Q16);
      b1 = blend(a1, a2, (ONE_Q16 + u) >>> 1);
      b2 = blend(a2, a3, u >>> 1);
      c  = blend(b1, b2, u);
      if (c > COORD_MAX) begin
         c = COORD_MAX;
      end
      if (c < COORD_MIN) begin
         c = COORD_MIN;
      end
      return c[CRD_W-1:0];
   endfunction

   // Count a failure and describe the first few of them.
   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN) begin
         $display("%0t: mismatch: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin : watch
      int           count;
      longint       u;
      rsp_data_type smp;
      rsp_data_type want;
      if (reset) begin
         sps_cfg = SPS_RESET;
         expected_samples.delete();
         mismatch_count  = 0;
         segments_seen   = 0;
         samples_checked = 0;
      end else begin
         // Register writes update the local copy; reads must return it.
         if (csr_psel && csr_penable && csr_pready && csr_paddr == SPS_ADDR) begin
            if (csr_pwrite) begin
               sps_cfg = csr_pwdata[SPS_W-1:0];
            end else if (csr_prdata[SPS_W-1:0] !== sps_cfg) begin
               note_mismatch($sformatf("register read expected %0d, got %0d",
                                       sps_cfg, csr_prdata[SPS_W-1:0]));
            end
         end

         // An accepted request yields the clamped number of samples, evenly in u.
         if (req_valid && !req_stall) begin
            count = sps_cfg;
            if (count < 2) begin
               count = 2;
            end
            if (count > MAX_SAMPLES) begin
               count = MAX_SAMPLES;
            end
            for (int i = 0; i < count; i++) begin
               u = (longint'(i) * ONE_Q16) / (count - 1);
               smp.sample_x    = curve_coord(req_data, 0, u);
               smp.sample_y    = curve_coord(req_data, 1, u);
               smp.sample_z    = curve_coord(req_data, 2, u);
               smp.last_sample = (i == count - 1);
               expected_samples = {expected_samples, smp};
            end
            segments_seen++;
         end

         // Each accepted sample is matched against the oldest expectation.
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               note_mismatch($sformatf("unexpected sample x=%h y=%h z=%h last=%b",
                                       rsp_data.sample_x, rsp_data.sample_y,
                                       rsp_data.sample_z, rsp_data.last_sample));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_data.sample_x !== want.sample_x ||
                   rsp_data.sample_y !== want.sample_y ||
                   rsp_data.sample_z !== want.sample_z ||
                   rsp_data.last_sample !== want.last_sample) begin
                  note_mismatch($sformatf(
                     "sample %0d expected x=%h y=%h z=%h last=%b, got x=%h y=%h z=%h last=%b",
                     samples_checked, want.sample_x, want.sample_y, want.sample_z,
                     want.last_sample, rsp_data.sample_x, rsp_data.sample_y,
                     rsp_data.sample_z, rsp_data.last_sample));
               end
            end
            samples_checked++;
         end
      end
      samples_pending = expected_samples.size();
   end

endmodule

/* bench/catmull_rom_spline_sampler_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Catmull-Rom spline sampler testbench
// Sends directed and random control-point requests under several sample
// counts, with random gaps and output stalls, and reports the verdict of the
// checker that predicts and compares every curve sample.
// ----------------------------------------------------------------------------
module catmull_rom_spline_sampler_test;
   import crs_pkg::*;

   localparam int MAX_SAMPLES     = 64;
   localparam int REQ_W           = $bits(req_data_type);
   localparam int NUM_FIELDS      = 12;
   localparam int IDLE_PCT        = 28;
   localparam int SMOOTH_PCT      = 55;
   localparam int WILD_PCT        = 25;
   localparam int DIRECTED_COUNT  = 13;
   localparam int PHASE_COUNT     = 10;
   localparam int ITEMS_PER_PHASE = 39;
   localparam int QUIET_PHASE     = 4;
   localparam int HOLD_PHASE      = 6;
   localparam logic [CSR_ADDR_W-1:0] SPS_ADDR = {REG_SPS, 2'b00};
   localparam logic [CRD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic [CRD_W-1:0] COORD_MIN = 32'h8000_0000;
   localparam logic [CRD_W-1:0] COORD_ONE = 32'h0001_0000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_data_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_data_type          rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatch_count;
   int                    samples_pending;
   int                    segments_seen;
   int                    samples_checked;
   logic                  quiet_mode = 1'b0;
   int                    settings_used = 0;

   // Sample counts per phase: both clamp ends, the range ends and a few inside.
   logic [SPS_W-1:0] sps_plan [PHASE_COUNT] =
      '{7'd2, 7'd64, 7'd0, 7'd1, 7'd127, 7'd65, 7'd3, 7'd33, 7'd5, 7'd16};

   catmull_rom_spline_sampler #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_top (.*);

   catmull_rom_spline_sampler_checker #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_checker (.*);

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Output stalls at random, except during the quiet stretch.
   always @(negedge clock) begin
      rsp_stall <= !quiet_mode && ($urandom_range(99) < IDLE_PCT);
   end

   // Watchdog.
   initial begin
      #4_000_000;
      $display("Run timed out with %0d samples still expected.", samples_pending);
      $display("*** FAILED ***");
      $finish;
   end

   // Place one coordinate into its slot of the flat request word.
   function automatic logic [REQ_W-1:0] put_coord(input logic [REQ_W-1:0] flat,
                                                  input int point, input int axis,
                                                  input logic [CRD_W-1:0] value);
      flat[CRD_W*(NUM_FIELDS-1-(3*point+axis)) +: CRD_W] = value;
      return flat;
   endfunction

   // Directed request: x takes the four points as given, y takes them in
   // reverse order and z takes their bitwise complement.
   function automatic req_data_type corner_segment(input logic [CRD_W-1:0] p0, p1, p2, p3);
      logic [CRD_W-1:0] pts[4];
      logic [REQ_W-1:0] flat;
      pts  = '{p0, p1, p2, p3};
      flat = '0;
      for (int k = 0; k < 4; k++) begin
         flat = put_coord(flat, k, 0, pts[k]);
         flat = put_coord(flat, k, 1, pts[3-k]);
         flat = put_coord(flat, k, 2, ~pts[k]);
      end
      return flat;
   endfunction

   function automatic req_data_type directed_segment(input int idx);
      case (idx)
         0:       return corner_segment('0, '0, '0, '0);
         1:       return corner_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
         2:       return corner_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
         // Alternating extremes push the lerp points far past the 32-bit range.
         3:       return corner_segment(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
         4:       return corner_segment(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
         5:       return corner_segment('0, COORD_MIN, COORD_MAX, '0);
         6:       return corner_segment(COORD_MAX, '0, '0, COORD_MIN);
         // Evenly spaced points give a straight line.
         7:       return corner_segment('0, COORD_ONE, 2 * COORD_ONE, 3 * COORD_ONE);
         8:       return corner_segment('1, '1, '1, '1);
         // Single-LSB steps show the rounding toward minus infinity.
         9:       return corner_segment('0, 32'd1, '1, 32'd3);
         10:      return corner_segment(32'h1234_5678, 32'h8765_4321,
                                        32'h0F0F_0F0F, 32'hF0F0_F0F0);
         11:      return corner_segment(32'h4000_0000, 32'h7FFF_0000,
                                        32'h8001_0000, 32'hC000_0000);
         default: return corner_segment(32'hFFFA_8000, 32'h0002_8000,
                                        32'h0007_0000, 32'hFFFF_0001);
      endcase
   endfunction

   // Random request: mostly smooth point sequences, some fully random words
   // and some mixes of extreme values.
   function automatic req_data_type random_segment();
      logic [REQ_W-1:0] flat;
      logic [CRD_W-1:0] value;
      int               style;
      int               origin;
      int               stride;
      int               wobble;
      flat  = '0;
      style = $urandom_range(99);
      for (int axis = 0; axis < 3; axis++) begin
         origin = int'($urandom) >>> 7;
         stride = int'($urandom) >>> 11;
         for (int k = 0; k < 4; k++) begin
            wobble = int'($urandom) >>> 20;
            if (style < SMOOTH_PCT) begin
               value = origin + k * stride + wobble;
            end else if (style < SMOOTH_PCT + WILD_PCT) begin
               value = $urandom;
            end else begin
               case ($urandom_range(5))
                  0:       value = COORD_MAX;
                  1:       value = COORD_MIN;
                  2:       value = '0;
                  3:       value = '1;
                  4:       value = 32'd1;
                  default: value = $urandom;
               endcase
            end
            flat = put_coord(flat, k, axis, value);
         end
      end
      return flat;
   endfunction

   // Offer one request after a random gap and hold it until it is taken.
   task automatic send_segment(input req_data_type seg);
      @(negedge clock);
      if (!quiet_mode) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= seg;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Stop sending and wait until every expected sample has arrived and the
   // pipeline has had time to settle.
   task automatic drain_samples();
      @(negedge clock);
      req_valid <= 1'b0;
      while (samples_pending != 0) begin
         @(negedge clock);
      end
      repeat (PIPE_LAT + 4) @(negedge clock);
   endtask

   // One register access: setup cycle, then access cycle until ready.
   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= write;
      csr_paddr   <= SPS_ADDR;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed requests at the reset sample count.
      for (int idx = 0; idx < DIRECTED_COUNT; idx++) begin
         send_segment(directed_segment(idx));
      end

      // Random phases, each under its own sample count.
      sps_plan[PHASE_COUNT-2] = SPS_W'($urandom_range(2, MAX_SAMPLES));
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_samples();
         csr_access(1'b1, CSR_DATA_W'(sps_plan[phase]));
         csr_access(1'b0, '0);
         settings_used++;
         quiet_mode <= (phase == QUIET_PHASE);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == HOLD_PHASE && n == ITEMS_PER_PHASE / 2) begin
               drain_samples();
            end
            send_segment(random_segment());
         end
      end
      drain_samples();

      $display("Sent %0d control-point requests and checked %0d curve samples,",
               segments_seen, samples_checked);
      $display("over %0d register settings from clamped-low to clamped-high counts.",
               settings_used + 1);
      if (mismatch_count == 0 && samples_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sim.f */
src/crs_pkg.sv
src/crs_sequencer.sv
src/crs_lane.sv
src/catmull_rom_spline_sampler.sv
bench/catmull_rom_spline_sampler_checker.sv
bench/catmull_rom_spline_sampler_test.sv
